// File: src/group_aggregate_state_table_unit_defines.svh
// Assertion macros used by the checker.
`ifndef GROUP_AGGREGATE_STATE_TABLE_UNIT_DEFINES_SVH
`define GROUP_AGGREGATE_STATE_TABLE_UNIT_DEFINES_SVH

// Checked outside reset.
`define GAST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked during reset too.
`define GAST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/gast_pkg.sv
package gast_pkg;

  localparam int DEF_GROUPS = 4096;
  localparam int DEF_SLOTS  = 4;
  localparam int MAX_SLOTS  = 4;

  localparam int VAL_W = 64;
  localparam int CNT_W = 40;
  localparam int GRP_W = 12;

  localparam logic [1:0] OP_NEW  = 2'd0;
  localparam logic [1:0] OP_UPD  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [1:0] REPLY_ASSIGNED = 2'd0;
  localparam logic [1:0] REPLY_RESULT   = 2'd1;
  localparam logic [1:0] REPLY_FULL     = 2'd2;
  localparam logic [1:0] REPLY_UNKNOWN  = 2'd3;

  localparam logic [2:0] KIND_COUNT = 3'd0;
  localparam logic [2:0] KIND_SUM   = 3'd1;
  localparam logic [2:0] KIND_AVG   = 3'd2;
  localparam logic [2:0] KIND_MIN   = 3'd3;
  localparam logic [2:0] KIND_MAX   = 3'd4;

  localparam logic [2:0] CFG_SLOTS_USED = 3'd0;
  localparam logic [2:0] CFG_KIND_0     = 3'd1;
  localparam logic [2:0] CFG_KIND_3     = 3'd4;

  typedef struct packed {
    logic [VAL_W-1:0] acc;
    logic [VAL_W-1:0] hi;
    logic [CNT_W-1:0] cnt;
    logic             hv;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic clr;
    logic upd;
    logic rd;
  } lane_ctrl_t;

endpackage

// File: src/gast_ram.sv
module gast_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/gast_div.sv
module gast_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [gast_pkg::VAL_W-1:0]   hi,
  input  logic [gast_pkg::VAL_W-1:0]   lo,
  input  logic [gast_pkg::CNT_W-1:0]   divisor,
  output logic                         done,
  output logic [gast_pkg::VAL_W-1:0]   quotient
);

  localparam int DW = 2 * gast_pkg::VAL_W;
  localparam int CW = gast_pkg::CNT_W;

  logic          busy;
  logic [6:0]    step;
  logic          neg;
  logic [DW-1:0] dvd;
  logic [CW-1:0] dvs;
  logic [CW-1:0] rem;
  logic [gast_pkg::VAL_W-1:0] quo;

  logic [CW:0]   cur;
  logic [CW:0]   diff;
  logic          ge;

  assign cur  = {rem, dvd[DW-1]};
  assign diff = cur - {1'b0, dvs};
  assign ge   = cur >= {1'b0, dvs};
  assign quotient = neg ? (~quo + 1'b1) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && step == 7'd127) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= hi[gast_pkg::VAL_W-1];
      dvd  <= hi[gast_pkg::VAL_W-1] ? (~{hi, lo} + 1'b1) : {hi, lo};
      dvs  <= divisor;
      rem  <= '0;
      quo  <= '0;
      step <= '0;
    end else if (busy) begin
      dvd  <= {dvd[DW-2:0], 1'b0};
      rem  <= ge ? diff[CW-1:0] : cur[CW-1:0];
      quo  <= {quo[gast_pkg::VAL_W-2:0], ge};
      step <= step + 7'd1;
    end
  end

endmodule

// File: src/gast_lane.sv
module gast_lane #(
  parameter int GROUPS = gast_pkg::DEF_GROUPS,
  localparam int AW = (GROUPS > 1) ? $clog2(GROUPS) : 1
) (
  input  logic                       clk,
  input  gast_pkg::lane_ctrl_t       ctrl,
  input  logic                       active,
  input  logic [2:0]                 kind,
  input  logic [AW-1:0]              waddr,
  input  logic [AW-1:0]              raddr,
  input  logic [gast_pkg::VAL_W-1:0] value,
  input  logic                       is_null,
  output gast_pkg::entry_t           rdata
);

  gast_pkg::entry_t upd;
  gast_pkg::entry_t wdata;
  logic             we;
  logic [2*gast_pkg::VAL_W-1:0] wide;
  logic             better;

  assign wide = {rdata.hi, rdata.acc} + {{gast_pkg::VAL_W{value[gast_pkg::VAL_W-1]}}, value};

  always_comb begin
    better = 1'b0;
    upd    = rdata;
    if (kind == gast_pkg::KIND_MIN) begin
      better = $signed(value) < $signed(rdata.acc);
    end else begin
      better = $signed(rdata.acc) < $signed(value);
    end
    unique case (kind)
      gast_pkg::KIND_COUNT: begin
        upd.acc = rdata.acc + 1'b1;
      end
      gast_pkg::KIND_SUM: begin
        if (!is_null) begin
          upd.acc = rdata.acc + value;
          upd.hv  = 1'b1;
        end
      end
      gast_pkg::KIND_AVG: begin
        if (!is_null) begin
          upd.acc = wide[gast_pkg::VAL_W-1:0];
          upd.hi  = wide[2*gast_pkg::VAL_W-1:gast_pkg::VAL_W];
          upd.cnt = rdata.cnt + 1'b1;
        end
      end
      gast_pkg::KIND_MIN, gast_pkg::KIND_MAX: begin
        if (!is_null && (!rdata.hv || better)) begin
          upd.acc = value;
          upd.hv  = 1'b1;
        end
      end
      default: begin
        upd = rdata;
      end
    endcase
  end

  assign we    = ctrl.clr || (ctrl.upd && active);
  assign wdata = ctrl.clr ? '0 : upd;

  gast_ram #(
    .WIDTH(gast_pkg::ENTRY_W),
    .DEPTH(GROUPS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (ctrl.rd),
    .raddr(raddr),
    .rdata(rdata)
  );

endmodule

// File: src/group_aggregate_state_table_unit.sv
// Per-group aggregate table. Each of the SLOTS lanes holds one aggregate slot of every group in
// its own memory and updates it by read-modify-write. A new-group transaction is answered from
// the lookup state; an update or a plain read does a memory read, then a write back or a result;
// a read of an average then runs the bit-serial 128-by-40 divider. One transaction is in work
// at a time; a finished result waits in the output register. Entries are cleared when their
// group is assigned, so no clearing pass runs after reset.
module group_aggregate_state_table_unit #(
  parameter int GROUPS = gast_pkg::DEF_GROUPS,
  parameter int SLOTS  = gast_pkg::DEF_SLOTS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // group, value_0, value_1, value_2, value_3, null_0, null_1, null_2, null_3, slot
  input  logic [279:0] s_tdata,
  // op
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // new_group, result_value, result_null
  output logic [79:0]  m_tdata,
  // reply
  output logic [1:0]   m_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [2:0]   cfg_data
);

  localparam int AW   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int GCW  = $clog2(GROUPS + 1);
  localparam int CMPW = (GCW > gast_pkg::GRP_W) ? GCW : gast_pkg::GRP_W;
  localparam int VW   = gast_pkg::VAL_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_DATA = 2'd2;
  localparam logic [1:0] ST_DIV  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  logic [2:0] slots_used;
  logic [2:0] kind [gast_pkg::MAX_SLOTS];
  logic [GCW-1:0] group_count;

  logic [1:0]  op;
  logic [gast_pkg::GRP_W-1:0] grp;
  logic [VW-1:0] val [gast_pkg::MAX_SLOTS];
  logic [gast_pkg::MAX_SLOTS-1:0] nul;
  logic [1:0]  slot;

  logic [1:0]  out_reply;
  logic [gast_pkg::GRP_W-1:0] out_ng;
  logic [VW-1:0] out_val;
  logic        out_null;

  logic [2:0]  act_n;
  logic        known;
  logic        full;
  logic        out_free;
  logic        slot_ok;
  logic [CMPW-1:0] gc_ext;
  gast_pkg::lane_ctrl_t ctrl;
  gast_pkg::entry_t lane_rd [SLOTS];
  gast_pkg::entry_t sel;
  logic [2:0]  sel_kind;
  logic        div_start;
  logic        div_done;
  logic [VW-1:0] div_q;

  logic        emit;
  logic [1:0]  emit_reply;
  logic [gast_pkg::GRP_W-1:0] emit_ng;
  logic [VW-1:0] emit_val;
  logic        emit_null;
  logic        gc_inc;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign out_free  = !m_tvalid || m_tready;
  assign m_tuser   = out_reply;
  assign m_tdata   = {3'b0, out_null, out_val, out_ng};

  assign act_n   = (slots_used > 3'(SLOTS)) ? 3'(SLOTS) : slots_used;
  assign gc_ext  = CMPW'(group_count);
  assign known   = CMPW'(grp) < gc_ext;
  assign full    = group_count == GCW'(GROUPS);
  assign slot_ok = (3'(slot) < act_n) && (3'(slot) < 3'(SLOTS));
  assign sel_kind = kind[slot];

  always_comb begin
    sel = lane_rd[0];
    for (int s = 0; s < SLOTS; s++) begin
      if (2'(s) == slot) begin
        sel = lane_rd[s];
      end
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    div_start  = 1'b0;
    emit       = 1'b0;
    emit_reply = gast_pkg::REPLY_RESULT;
    emit_ng    = '0;
    emit_val   = '0;
    emit_null  = 1'b0;
    gc_inc     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        priority if (op == gast_pkg::OP_NEW) begin
          if (out_free) begin
            emit = 1'b1;
            state_next = ST_IDLE;
            if (full) begin
              emit_reply = gast_pkg::REPLY_FULL;
            end else begin
              emit_reply = gast_pkg::REPLY_ASSIGNED;
              emit_ng    = gc_ext[gast_pkg::GRP_W-1:0];
              ctrl.clr   = 1'b1;
              gc_inc     = 1'b1;
            end
          end
        end else if ((op == gast_pkg::OP_UPD || op == gast_pkg::OP_READ) && known) begin
          ctrl.rd = 1'b1;
          state_next = ST_DATA;
        end else if (op == gast_pkg::OP_READ) begin
          if (out_free) begin
            emit = 1'b1;
            emit_reply = gast_pkg::REPLY_UNKNOWN;
            state_next = ST_IDLE;
          end
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DATA: begin
        if (op == gast_pkg::OP_UPD) begin
          ctrl.upd = 1'b1;
          state_next = ST_IDLE;
        end else if (slot_ok && sel_kind == gast_pkg::KIND_AVG && sel.cnt != '0) begin
          div_start = 1'b1;
          state_next = ST_DIV;
        end else if (out_free) begin
          emit = 1'b1;
          state_next = ST_IDLE;
          if (!slot_ok) begin
            emit_null = 1'b1;
          end else if (sel_kind == gast_pkg::KIND_COUNT) begin
            emit_val = sel.acc;
          end else if ((sel_kind == gast_pkg::KIND_SUM || sel_kind == gast_pkg::KIND_MIN ||
                        sel_kind == gast_pkg::KIND_MAX) && sel.hv) begin
            emit_val = sel.acc;
          end else begin
            emit_null = 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (div_done && out_free) begin
          emit = 1'b1;
          emit_val = div_q;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      group_count <= '0;
      m_tvalid    <= 1'b0;
      slots_used  <= 3'd1;
      for (int k = 0; k < gast_pkg::MAX_SLOTS; k++) begin
        kind[k] <= gast_pkg::KIND_COUNT;
      end
    end else begin
      state <= state_next;
      if (gc_inc) begin
        group_count <= group_count + 1'b1;
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == gast_pkg::CFG_SLOTS_USED) begin
          slots_used <= cfg_data;
        end else if (cfg_index <= gast_pkg::CFG_KIND_3) begin
          kind[2'(cfg_index - gast_pkg::CFG_KIND_0)] <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op   <= s_tuser;
      grp  <= s_tdata[11:0];
      val[0] <= s_tdata[75:12];
      val[1] <= s_tdata[139:76];
      val[2] <= s_tdata[203:140];
      val[3] <= s_tdata[267:204];
      nul  <= s_tdata[271:268];
      slot <= s_tdata[273:272];
    end
    if (emit) begin
      out_reply <= emit_reply;
      out_ng    <= emit_ng;
      out_val   <= emit_val;
      out_null  <= emit_null;
    end
  end

  for (genvar s = 0; s < SLOTS; s++) begin : g_lane
    gast_lane #(
      .GROUPS(GROUPS)
    ) u_lane (
      .clk    (clk),
      .ctrl   (ctrl),
      .active (3'(s) < act_n),
      .kind   (kind[s]),
      .waddr  (ctrl.clr ? gc_ext[AW-1:0] : AW'(CMPW'(grp))),
      .raddr  (AW'(CMPW'(grp))),
      .value  (val[s]),
      .is_null(nul[s]),
      .rdata  (lane_rd[s])
    );
  end

  gast_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .hi      (sel.hi),
    .lo      (sel.acc),
    .divisor (sel.cnt),
    .done    (div_done),
    .quotient(div_q)
  );

endmodule

// File: src/gast_check.sv
`include "group_aggregate_state_table_unit_defines.svh"

module gast_check (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [79:0]  m_tdata,
  input logic [1:0]   m_tuser
);

  `GAST_ASSERT_ALWAYS(a_idle_after_reset, rst |=> !m_tvalid, "result after reset")
  `GAST_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result dropped")
  `GAST_ASSERT(a_no_payload, m_tvalid && (m_tuser == gast_pkg::REPLY_FULL || m_tuser == gast_pkg::REPLY_UNKNOWN) |-> m_tdata == '0, "stray payload")
  `GAST_ASSERT(a_assign_clean, m_tvalid && m_tuser == gast_pkg::REPLY_ASSIGNED |-> m_tdata[79:12] == '0, "stray value")
  `GAST_ASSERT(a_one_in_work, s_tvalid && s_tready |=> !s_tready, "second transaction taken")

endmodule

bind group_aggregate_state_table_unit gast_check u_check (.*);
